/* rtl/wsl_pkg.sv */
`default_nettype none

package wsl_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 24;
  localparam int WT_W      = 24;
  localparam int SUM_W     = 40;
  localparam int RES_W     = 32;
  localparam int E_W       = FRAC_BITS + 1;
  localparam int MAG_W     = VAL_W + 1;

  localparam logic [E_W-1:0]   UNIT  = E_W'(64'd1 << FRAC_BITS);
  localparam logic [WT_W-1:0]  W_ONE = ((64'd1 << FRAC_BITS) > 64'hFF_FFFF) ?
                                       24'hFF_FFFF : WT_W'(64'd1 << FRAC_BITS);
  localparam logic [63:0]      HALF  = 64'd1 << (FRAC_BITS - 1);
  localparam logic [VAL_W-1:0] VAL_MIN = 24'h80_0000;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [RES_W-1:0] LSE_EMPTY = 32'h8000_0000;

  localparam logic [31:0]      LOG2E_LO  = 32'd1901360723;
  localparam logic [31:0]      LN2_Q32   = 32'd2977044472;
  localparam logic [MAG_W-1:0] EXP_LIMIT = MAG_W'(64'd48 << FRAC_BITS);
  localparam int               EXP_T_SH  = FRAC_BITS + 2;
  localparam logic [63:0]      EXP_T_RND = 64'd1 << (FRAC_BITS + 1);
  localparam int               LN_SH     = 56 - FRAC_BITS;
  localparam logic [63:0]      LN_RND    = 64'd1 << (LN_SH - 1);

  localparam int EXP_STEPS = 20;
  localparam int LN_ROUNDS = 24;
  localparam int DIV_STEPS = FRAC_BITS + 1;

  localparam logic [1:0] CFG_MODE        = 2'd0;
  localparam logic [1:0] CFG_USE_WEIGHTS = 2'd1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_DROP = 2'd2
  } status_t;

  typedef logic [30:0] ctab_t [EXP_STEPS];

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Factors 2^(-2^-(j+1)) in Q30 for the fraction bits of the exponent, top bit first.
  function automatic ctab_t exp_ctab();
    ctab_t       t;
    logic [63:0] c;
    c = 64'd1 << 29;
    for (int j = 0; j < EXP_STEPS; j++) begin
      c = isqrt64(c << 30);
      t[j] = c[30:0];
    end
    return t;
  endfunction

  localparam ctab_t EXP_CTAB = exp_ctab();

endpackage

`default_nettype wire

/* rtl/wsl_ram.sv */
`default_nettype none

module wsl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/weighted_softmax_logsumexp.sv */
// Loading a stored element: accept, the shared exp sequence (its first step only when the gap to the
// maximum is 48.0 or more), then the sum update states S_UPD_A to S_UPD_C as needed.
// A dropped element skips the exp sequence and the sum update. Log-sum-exp output after the last element:
// finish, normalize, squaring rounds for 24 fraction bits of log2, multiply by ln 2, output.
// Softmax output per element: RAM read, load, exp sequence, multiply, divide to a 17-bit quotient,
// output; an underflowing exp runs only its first step, and a zero weight sum goes from load to output.
// All multiplications run through one 32x32 multiplier; the divide uses one subtract-compare stage.
// Synchronous active-low reset clears control state; the element RAM is not cleared.
`default_nettype none

module weighted_softmax_logsumexp import wsl_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic signed [VAL_W-1:0]  in_elem_value,
  input  wire logic        [WT_W-1:0]   in_elem_weight,
  input  wire logic                     in_last,
  output logic                          out_valid,
  output logic signed      [RES_W-1:0]  out_result_value,
  output logic             [1:0]        out_status,
  output logic                          out_is_last,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic        [1:0]        cfg_index,
  input  wire logic                     cfg_data
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);

  typedef enum logic [16:0] {
    S_IDLE    = 17'h00001,
    S_EXP_T   = 17'h00002,
    S_EXP_M   = 17'h00004,
    S_EXP_S   = 17'h00008,
    S_UPD_A   = 17'h00010,
    S_UPD_B   = 17'h00020,
    S_UPD_C   = 17'h00040,
    S_FIN     = 17'h00080,
    S_LN_NORM = 17'h00100,
    S_LN_SQ   = 17'h00200,
    S_LN_MUL  = 17'h00400,
    S_LN_OUT  = 17'h00800,
    S_SM_RD   = 17'h01000,
    S_SM_LD   = 17'h02000,
    S_SM_MUL  = 17'h04000,
    S_SM_DIV  = 17'h08000,
    S_SM_OUT  = 17'h10000
  } state_t;

  state_t                   state_r;
  logic                     phase_sm_r;
  logic                     mode_r;
  logic                     usew_r;
  logic [CW-1:0]            cnt_r;
  logic [CW-1:0]            idx_r;
  logic signed [VAL_W-1:0]  max_r;
  logic signed [VAL_W-1:0]  val_r;
  logic [WT_W-1:0]          wt_r;
  logic [SUM_W-1:0]         sum_r;
  logic                     ovf_r;
  logic                     last_r;
  logic                     bigger_r;
  logic [MAG_W-1:0]         mag_r;
  logic [E_W-1:0]           e_r;
  logic [6:0]               k_r;
  logic [29:0]              f_r;
  logic [30:0]              m_r;
  logic [4:0]               it_r;
  logic [63:0]              acc_r;
  logic [55:0]              dvs_r;
  logic [E_W-1:0]           q_r;
  logic [SUM_W-1:0]         x_r;
  logic [5:0]               n_r;
  logic [23:0]              frac_r;
  logic                     ln_neg_r;
  logic                     out_valid_r;
  logic [RES_W-1:0]         out_value_r;
  logic [1:0]               out_status_r;
  logic                     out_is_last_r;

  logic                     accept;
  logic                     store;
  logic [WT_W-1:0]          in_wt;
  logic signed [25:0]       diff_in;
  logic [25:0]              diff_abs;
  logic                     in_bigger;
  logic [47:0]              ram_rdata;
  logic signed [VAL_W-1:0]  rd_val;
  logic signed [25:0]       diff_rd;
  logic [31:0]              mul_a;
  logic [31:0]              mul_b;
  logic [63:0]              mul_p;
  logic [63:0]              t64;
  logic [7:0]               exp_s;
  logic [63:0]              exp_sh;
  logic [E_W-1:0]           e_fin;
  logic [31:0]              sq;
  logic [6:0]               nn;
  logic [30:0]              lg;
  logic [30:0]              lg_mag;
  logic [63:0]              ln_r;
  logic [RES_W-1:0]         lse_v;
  logic [63:0]              upd_b_sum;
  logic [63:0]              term;
  logic [E_W-1:0]           p_sat;
  status_t                  status_w;
  logic                     sm_last;
  state_t                   after_exp;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
  endfunction

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && (state_r == S_IDLE);
  assign store     = (cnt_r != CW'(MAX_LEN));
  assign in_wt     = usew_r ? in_elem_weight : W_ONE;
  assign diff_in   = 26'(in_elem_value) - 26'(max_r);
  assign diff_abs  = diff_in[25] ? 26'(-diff_in) : 26'(diff_in);
  assign in_bigger = !diff_in[25] && (diff_in != 26'sd0);
  assign rd_val    = signed'(ram_rdata[VAL_W-1:0]);
  assign diff_rd   = 26'(max_r) - 26'(rd_val);
  assign after_exp = phase_sm_r ? S_SM_MUL : S_UPD_A;

  wsl_ram #(
    .WIDTH(WT_W + VAL_W),
    .DEPTH(MAX_LEN)
  ) u_store (
    .clk  (clk),
    .we   (accept && store),
    .waddr(cnt_r[AW-1:0]),
    .wdata({in_wt, in_elem_value}),
    .raddr(idx_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_EXP_T: begin
        mul_a = 32'(mag_r);
        mul_b = LOG2E_LO;
      end
      S_EXP_M: begin
        mul_a = 32'(m_r);
        mul_b = 32'(EXP_CTAB[it_r]);
      end
      S_UPD_A: begin
        mul_a = bigger_r ? sum_r[31:0] : 32'(wt_r);
        mul_b = 32'(e_r);
      end
      S_UPD_B: begin
        mul_a = 32'(sum_r[SUM_W-1:32]);
        mul_b = 32'(e_r);
      end
      S_LN_SQ: begin
        mul_a = 32'(m_r);
        mul_b = 32'(m_r);
      end
      S_LN_MUL: begin
        mul_a = 32'(lg_mag[29:0]);
        mul_b = LN2_Q32;
      end
      S_SM_MUL: begin
        mul_a = 32'(wt_r);
        mul_b = 32'(e_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p     = mul_a * mul_b;
  assign t64       = (64'(mag_r) << 32) + mul_p + EXP_T_RND;
  assign exp_s     = 8'(k_r) + 8'(30 - FRAC_BITS);
  assign exp_sh    = (64'(m_r) + (64'd1 << (exp_s - 8'd1))) >> exp_s;
  assign e_fin     = (exp_s >= 8'd32) ? '0 : exp_sh[E_W-1:0];
  assign sq        = mul_p[61:30];
  assign nn        = {1'b0, n_r} - 7'(FRAC_BITS);
  assign lg        = {nn, frac_r};
  assign lg_mag    = lg[30] ? 31'(-lg) : lg;
  assign ln_r      = (mul_p + LN_RND) >> LN_SH;
  assign lse_v     = 32'(max_r) + (ln_neg_r ? 32'(-32'(acc_r[21:0])) : 32'(acc_r[21:0]));
  assign upd_b_sum = (mul_p << 32) + acc_r + HALF;
  assign term      = (mul_p + HALF) >> FRAC_BITS;
  assign p_sat     = (q_r > UNIT) ? UNIT : q_r;
  assign status_w  = (sum_r == '0) ? ST_ZERO : (ovf_r ? ST_DROP : ST_OK);
  assign sm_last   = (CW'(idx_r + 1'b1) == cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_sm_r  <= 1'b0;
      mode_r      <= 1'b0;
      usew_r      <= 1'b1;
      cnt_r       <= '0;
      idx_r       <= '0;
      max_r       <= VAL_MIN;
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MODE:        mode_r <= cfg_data;
          CFG_USE_WEIGHTS: usew_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            val_r    <= in_elem_value;
            wt_r     <= in_wt;
            last_r   <= in_last;
            bigger_r <= in_bigger;
            mag_r    <= diff_abs[MAG_W-1:0];
            if (store) begin
              cnt_r      <= CW'(cnt_r + 1'b1);
              phase_sm_r <= 1'b0;
              state_r    <= S_EXP_T;
            end else begin
              ovf_r   <= 1'b1;
              state_r <= in_last ? S_FIN : S_IDLE;
            end
          end
        end
        S_EXP_T: begin
          if (mag_r >= EXP_LIMIT) begin
            e_r     <= '0;
            state_r <= after_exp;
          end else begin
            k_r     <= t64[EXP_T_SH+36:EXP_T_SH+30];
            f_r     <= t64[EXP_T_SH+29:EXP_T_SH];
            m_r     <= 31'h4000_0000;
            it_r    <= '0;
            state_r <= S_EXP_M;
          end
        end
        S_EXP_M: begin
          if (f_r[29]) begin
            m_r <= 31'((mul_p + 64'h2000_0000) >> 30);
          end
          f_r  <= {f_r[28:0], 1'b0};
          it_r <= 5'(it_r + 1'b1);
          if (it_r == 5'(EXP_STEPS - 1)) begin
            state_r <= S_EXP_S;
          end
        end
        S_EXP_S: begin
          e_r     <= e_fin;
          state_r <= after_exp;
        end
        S_UPD_A: begin
          if (bigger_r) begin
            if (e_r < UNIT) begin
              acc_r   <= mul_p;
              state_r <= S_UPD_B;
            end else begin
              state_r <= S_UPD_C;
            end
          end else begin
            sum_r   <= sat_add(sum_r, term[SUM_W-1:0]);
            state_r <= last_r ? S_FIN : S_IDLE;
          end
        end
        S_UPD_B: begin
          sum_r   <= upd_b_sum[FRAC_BITS+SUM_W-1:FRAC_BITS];
          state_r <= S_UPD_C;
        end
        S_UPD_C: begin
          sum_r   <= sat_add(sum_r, SUM_W'(wt_r));
          max_r   <= val_r;
          state_r <= last_r ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          if (!mode_r) begin
            if (sum_r == '0) begin
              out_valid_r   <= 1'b1;
              out_value_r   <= LSE_EMPTY;
              out_status_r  <= ST_ZERO;
              out_is_last_r <= 1'b1;
              cnt_r         <= '0;
              max_r         <= VAL_MIN;
              ovf_r         <= 1'b0;
              state_r       <= S_IDLE;
            end else begin
              x_r     <= sum_r;
              n_r     <= 6'(SUM_W - 1);
              state_r <= S_LN_NORM;
            end
          end else begin
            idx_r   <= '0;
            state_r <= S_SM_RD;
          end
        end
        S_LN_NORM: begin
          if (x_r[SUM_W-1]) begin
            m_r     <= x_r[SUM_W-1:SUM_W-31];
            it_r    <= '0;
            frac_r  <= '0;
            state_r <= S_LN_SQ;
          end else begin
            x_r <= {x_r[SUM_W-2:0], 1'b0};
            n_r <= 6'(n_r - 1'b1);
          end
        end
        S_LN_SQ: begin
          if (sq[31]) begin
            m_r    <= sq[31:1];
            frac_r <= {frac_r[22:0], 1'b1};
          end else begin
            m_r    <= sq[30:0];
            frac_r <= {frac_r[22:0], 1'b0};
          end
          it_r <= 5'(it_r + 1'b1);
          if (it_r == 5'(LN_ROUNDS - 1)) begin
            state_r <= S_LN_MUL;
          end
        end
        S_LN_MUL: begin
          acc_r    <= ln_r;
          ln_neg_r <= lg[30];
          state_r  <= S_LN_OUT;
        end
        S_LN_OUT: begin
          out_valid_r   <= 1'b1;
          out_value_r   <= lse_v;
          out_status_r  <= status_w;
          out_is_last_r <= 1'b1;
          cnt_r         <= '0;
          max_r         <= VAL_MIN;
          sum_r         <= '0;
          ovf_r         <= 1'b0;
          state_r       <= S_IDLE;
        end
        S_SM_RD: begin
          state_r <= S_SM_LD;
        end
        S_SM_LD: begin
          wt_r <= ram_rdata[WT_W+VAL_W-1:VAL_W];
          if (sum_r == '0) begin
            q_r     <= '0;
            state_r <= S_SM_OUT;
          end else begin
            mag_r      <= diff_rd[MAG_W-1:0];
            phase_sm_r <= 1'b1;
            state_r    <= S_EXP_T;
          end
        end
        S_SM_MUL: begin
          acc_r   <= mul_p + 64'(sum_r >> 1);
          dvs_r   <= {sum_r, 16'h0000};
          q_r     <= '0;
          it_r    <= '0;
          state_r <= S_SM_DIV;
        end
        S_SM_DIV: begin
          if (acc_r >= 64'(dvs_r)) begin
            acc_r <= acc_r - 64'(dvs_r);
            q_r   <= {q_r[E_W-2:0], 1'b1};
          end else begin
            q_r   <= {q_r[E_W-2:0], 1'b0};
          end
          dvs_r <= dvs_r >> 1;
          it_r  <= 5'(it_r + 1'b1);
          if (it_r == 5'(DIV_STEPS - 1)) begin
            state_r <= S_SM_OUT;
          end
        end
        S_SM_OUT: begin
          out_valid_r   <= 1'b1;
          out_value_r   <= 32'(p_sat);
          out_status_r  <= status_w;
          out_is_last_r <= sm_last;
          if (sm_last) begin
            cnt_r   <= '0;
            max_r   <= VAL_MIN;
            sum_r   <= '0;
            ovf_r   <= 1'b0;
            state_r <= S_IDLE;
          end else begin
            idx_r   <= CW'(idx_r + 1'b1);
            state_r <= S_SM_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = signed'(out_value_r);
  assign out_status       = out_status_r;
  assign out_is_last      = out_is_last_r;

  // A result transaction only follows one of the three result-producing states.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == S_FIN || $past(state_r) == S_LN_OUT ||
                     $past(state_r) == S_SM_OUT))
    else $error("result without a producing state");

  // The final result of a run leaves the sequencer idle with the vector cleared.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_is_last_r) |-> (state_r == S_IDLE && cnt_r == '0))
    else $error("run did not end cleanly");

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_LEN))
    else $error("element count beyond capacity");

endmodule

`default_nettype wire
